// ===== rtl/rrd_pkg.sv =====
// shared constants, codes and control structs of the round-robin dispatcher
`timescale 1ns / 1ps

package rrd_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int IDX_W         = $clog2(MAX_PROCESSES);
    localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);

    localparam int DATA_W        = 16;
    localparam int TIME_W        = 32;
    localparam int SLOT_W        = 4;
    localparam int PCOUNT_W      = 5;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 1;

    localparam logic [0:0] MODE_LOAD     = 1'b0;
    localparam logic [0:0] MODE_DISPATCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PCOUNT  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOADED     = 2'd0,
        KIND_DISPATCHED = 2'd1,
        KIND_IDLE_TICK  = 2'd2,
        KIND_ALL_DONE   = 2'd3
    } kind_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take;
        logic probe;
        logic scan;
        logic serve;
        logic emit;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic item_load;
        logic hit;
        logic scan_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/rrd_req_if.sv =====
// request channel: one table load or dispatch transaction
`timescale 1ns / 1ps

interface rrd_req_if;
    logic                        valid;
    logic                        ready;
    logic [0:0]                  mode;
    logic [rrd_pkg::SLOT_W-1:0]  slot;
    logic [rrd_pkg::DATA_W-1:0]  arrival;
    logic [rrd_pkg::DATA_W-1:0]  burst;

    modport source (output valid, output mode, output slot, output arrival, output burst,
                    input ready);
    modport sink   (input valid, input mode, input slot, input arrival, input burst,
                    output ready);
endinterface

// ===== rtl/rrd_rsp_if.sv =====
// response channel: one result transaction per request
`timescale 1ns / 1ps

interface rrd_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rrd_pkg::KIND_W-1:0]  kind;
    logic [rrd_pkg::SLOT_W-1:0]  served_slot;
    logic [rrd_pkg::DATA_W-1:0]  slice_length;
    logic [rrd_pkg::TIME_W-1:0]  slice_start;
    logic [rrd_pkg::TIME_W-1:0]  slice_stop;
    logic                        new_segment;

    modport source (output valid, output kind, output served_slot, output slice_length,
                    output slice_start, output slice_stop, output new_segment,
                    input ready);
    modport sink   (input valid, input kind, input served_slot, input slice_length,
                    input slice_start, input slice_stop, input new_segment,
                    output ready);
endinterface

// ===== rtl/rrd_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module rrd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rrd_ctrl.sv =====
// sequencing state machine: take, probe, scan, serve, emit
`timescale 1ns / 1ps

module rrd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rrd_pkg::ctrl_sts_t sts,
    output logic               in_ready,
    output rrd_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_SCAN,
        ST_SERVE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = sts.item_load ? ST_EMIT : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                cmd.probe  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    state_next = ST_SERVE;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SERVE:
            begin
                cmd.serve  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/rrd_datapath.sv =====
// process tables, scheduler state, scan logic, result and output registers
`timescale 1ns / 1ps

module rrd_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rrd_pkg::ctrl_cmd_t                  cmd,
    output rrd_pkg::ctrl_sts_t                  sts,
    input  logic                                cfg_we,
    input  logic [rrd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rrd_pkg::DATA_W-1:0]          cfg_data,
    input  logic [0:0]                          req_mode,
    input  logic [rrd_pkg::SLOT_W-1:0]          req_slot,
    input  logic [rrd_pkg::DATA_W-1:0]          req_arrival,
    input  logic [rrd_pkg::DATA_W-1:0]          req_burst,
    input  logic                                rsp_ready,
    output logic                                rsp_valid,
    output logic [rrd_pkg::KIND_W-1:0]          rsp_kind,
    output logic [rrd_pkg::SLOT_W-1:0]          rsp_served_slot,
    output logic [rrd_pkg::DATA_W-1:0]          rsp_slice_length,
    output logic [rrd_pkg::TIME_W-1:0]          rsp_slice_start,
    output logic [rrd_pkg::TIME_W-1:0]          rsp_slice_stop,
    output logic                                rsp_new_segment
);

    localparam int IDX_W  = rrd_pkg::IDX_W;
    localparam int CNT_W  = rrd_pkg::CNT_W;
    localparam int DATA_W = rrd_pkg::DATA_W;
    localparam int TIME_W = rrd_pkg::TIME_W;
    localparam int MAXP   = rrd_pkg::MAX_PROCESSES;

    // configuration and scheduler state
    logic [DATA_W-1:0]            quantum_reg;
    logic [rrd_pkg::PCOUNT_W-1:0] pcount_reg;
    logic [TIME_W-1:0]            time_reg;
    logic [IDX_W-1:0]             sstart_reg;
    logic [IDX_W-1:0]             last_reg;
    logic                         has_served_reg;
    logic [MAXP-1:0]              rem_vld_reg;
    logic                         out_valid_reg;

    // scan working registers
    logic                         rd_vld_reg;
    logic [IDX_W-1:0]             k_reg;
    logic [CNT_W-1:0]             i_reg;
    logic                         any_reg;
    logic [IDX_W-1:0]             found_reg;
    logic [DATA_W-1:0]            rem_hit_reg;

    // pending result and output registers
    rrd_pkg::kind_t               res_kind_reg;
    logic [rrd_pkg::SLOT_W-1:0]   res_slot_reg;
    logic [DATA_W-1:0]            res_slice_reg;
    logic [TIME_W-1:0]            res_start_reg;
    logic [TIME_W-1:0]            res_end_reg;
    logic                         res_seg_reg;
    rrd_pkg::kind_t               out_kind_reg;
    logic [rrd_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [DATA_W-1:0]            out_slice_reg;
    logic [TIME_W-1:0]            out_start_reg;
    logic [TIME_W-1:0]            out_end_reg;
    logic                         out_seg_reg;

    logic [CNT_W-1:0]             cnt;
    logic [IDX_W-1:0]             pos0;
    logic [IDX_W-1:0]             pos;
    logic [IDX_W-1:0]             k_step;
    logic [IDX_W-1:0]             raddr;
    logic [IDX_W-1:0]             waddr;
    logic                         slot_ok;
    logic                         load_wr;
    logic                         rem_we;
    logic [DATA_W-1:0]            rem_wdata;
    logic [DATA_W-1:0]            arr_rdata;
    logic [DATA_W-1:0]            rem_rdata;
    logic [DATA_W-1:0]            rem_cur;
    logic                         arrived;
    logic                         hit;
    logic                         scan_last;
    logic [DATA_W-1:0]            q_eff;
    logic [DATA_W-1:0]            charge;
    logic [TIME_W:0]              serve_sum;
    logic [TIME_W-1:0]            serve_end;
    logic [TIME_W-1:0]            tick_end;
    logic [IDX_W-1:0]             next_start;

    // entries in use, clamped to one..MAX_PROCESSES
    always_comb
    begin
        priority if (pcount_reg == '0)
        begin
            cnt = CNT_W'(1);
        end
        else if (32'(pcount_reg) > 32'(MAXP))
        begin
            cnt = CNT_W'(MAXP);
        end
        else
        begin
            cnt = CNT_W'(pcount_reg);
        end
    end

    assign pos0      = (CNT_W'(sstart_reg) < cnt) ? sstart_reg : '0;
    assign pos       = (TIME_W'(arr_rdata) > time_reg) ? '0 : k_reg;
    assign k_step    = ((CNT_W'(k_reg) + CNT_W'(1)) == cnt) ? '0 : k_reg + IDX_W'(1);
    assign slot_ok   = (32'(req_slot) < 32'(MAXP));
    assign load_wr   = cmd.take && (req_mode == rrd_pkg::MODE_LOAD) && slot_ok;

    assign rem_cur   = rd_vld_reg ? rem_rdata : '0;
    assign arrived   = (TIME_W'(arr_rdata) <= time_reg);
    assign hit       = arrived && (rem_cur != '0);
    assign scan_last = (i_reg == (cnt - CNT_W'(1)));

    assign q_eff     = (quantum_reg == '0) ? DATA_W'(1) : quantum_reg;
    assign charge    = (rem_hit_reg < q_eff) ? rem_hit_reg : q_eff;
    assign serve_sum = {1'b0, time_reg} + (TIME_W + 1)'(charge);
    assign serve_end = serve_sum[TIME_W] ? '1 : serve_sum[TIME_W-1:0];
    assign tick_end  = (time_reg == '1) ? time_reg : time_reg + TIME_W'(1);
    assign next_start = ((CNT_W'(found_reg) + CNT_W'(1)) >= cnt) ? '0
                                                                : found_reg + IDX_W'(1);

    // read address: start entry on take, search base on probe, next entry on scan
    always_comb
    begin
        priority if (cmd.take)
        begin
            raddr = pos0;
        end
        else if (cmd.probe)
        begin
            raddr = pos;
        end
        else if (cmd.scan)
        begin
            raddr = k_step;
        end
        else
        begin
            raddr = k_reg;
        end
    end

    assign rem_we    = load_wr || cmd.serve;
    assign waddr     = cmd.serve ? found_reg : IDX_W'(req_slot);
    assign rem_wdata = cmd.serve ? (rem_hit_reg - charge) : req_burst;

    rrd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAXP)
    ) u_arrival_ram (
        .clk   (clk),
        .we    (load_wr),
        .waddr (waddr),
        .wdata (req_arrival),
        .raddr (raddr),
        .rdata (arr_rdata)
    );

    rrd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAXP)
    ) u_remaining_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (waddr),
        .wdata (rem_wdata),
        .raddr (raddr),
        .rdata (rem_rdata)
    );

    assign sts.item_load = (req_mode == rrd_pkg::MODE_LOAD);
    assign sts.hit       = hit;
    assign sts.scan_last = scan_last;
    assign sts.out_free  = !out_valid_reg || rsp_ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg    <= DATA_W'(1);
            pcount_reg     <= rrd_pkg::PCOUNT_W'(16);
            time_reg       <= '0;
            sstart_reg     <= '0;
            last_reg       <= '0;
            has_served_reg <= 1'b0;
            rem_vld_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rrd_pkg::CFG_QUANTUM: quantum_reg <= cfg_data;
                    rrd_pkg::CFG_PCOUNT:  pcount_reg  <= cfg_data[rrd_pkg::PCOUNT_W-1:0];
                endcase
            end
            if (rem_we)
            begin
                rem_vld_reg[waddr] <= 1'b1;
            end
            if (cmd.scan && !hit && scan_last && (any_reg || rem_cur != '0))
            begin
                time_reg       <= tick_end;
                has_served_reg <= 1'b0;
            end
            if (cmd.serve)
            begin
                time_reg       <= serve_end;
                last_reg       <= found_reg;
                has_served_reg <= 1'b1;
                sstart_reg     <= next_start;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan and result payload
    always_ff @(posedge clk)
    begin
        rd_vld_reg <= rem_vld_reg[raddr];
        if (cmd.take)
        begin
            k_reg         <= pos0;
            res_kind_reg  <= rrd_pkg::KIND_LOADED;
            res_slot_reg  <= '0;
            res_slice_reg <= '0;
            res_start_reg <= '0;
            res_end_reg   <= '0;
            res_seg_reg   <= 1'b0;
        end
        if (cmd.probe)
        begin
            k_reg   <= pos;
            i_reg   <= '0;
            any_reg <= 1'b0;
        end
        if (cmd.scan)
        begin
            any_reg <= any_reg || (rem_cur != '0);
            if (hit)
            begin
                found_reg   <= k_reg;
                rem_hit_reg <= rem_cur;
            end
            else if (scan_last)
            begin
                res_slot_reg  <= '0;
                res_seg_reg   <= 1'b0;
                res_start_reg <= time_reg;
                if (any_reg || rem_cur != '0)
                begin
                    res_kind_reg  <= rrd_pkg::KIND_IDLE_TICK;
                    res_slice_reg <= DATA_W'(tick_end - time_reg);
                    res_end_reg   <= tick_end;
                end
                else
                begin
                    res_kind_reg  <= rrd_pkg::KIND_ALL_DONE;
                    res_slice_reg <= '0;
                    res_end_reg   <= time_reg;
                end
            end
            else
            begin
                k_reg <= k_step;
                i_reg <= i_reg + CNT_W'(1);
            end
        end
        if (cmd.serve)
        begin
            res_kind_reg  <= rrd_pkg::KIND_DISPATCHED;
            res_slot_reg  <= rrd_pkg::SLOT_W'(found_reg);
            res_slice_reg <= charge;
            res_start_reg <= time_reg;
            res_end_reg   <= serve_end;
            res_seg_reg   <= !has_served_reg || (found_reg != last_reg);
        end
        if (cmd.emit)
        begin
            out_kind_reg  <= res_kind_reg;
            out_slot_reg  <= res_slot_reg;
            out_slice_reg <= res_slice_reg;
            out_start_reg <= res_start_reg;
            out_end_reg   <= res_end_reg;
            out_seg_reg   <= res_seg_reg;
        end
    end

    assign rsp_valid        = out_valid_reg;
    assign rsp_kind         = out_kind_reg;
    assign rsp_served_slot  = out_slot_reg;
    assign rsp_slice_length = out_slice_reg;
    assign rsp_slice_start  = out_start_reg;
    assign rsp_slice_stop   = out_end_reg;
    assign rsp_new_segment  = out_seg_reg;

endmodule

// ===== rtl/round_robin_dispatcher.sv =====
// top level of the round-robin time-slice dispatcher
// sequence: a load is taken and then emitted; a dispatch is taken, probes its start entry,
//   scans entries, one per cycle, at most 16, serves when an entry is found, then emits
// one transaction at a time: no new request until its result is emitted, and the emit
//   waits while the sink holds off; reset: rst_n asynchronous, active low, clears time,
//   pointers and remaining work at once through per-entry valid bits, quantum 1, count 16
`timescale 1ns / 1ps

module round_robin_dispatcher (
    input  logic                          clk,
    input  logic                          rst_n,
    rrd_req_if.sink                       req,
    rrd_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [rrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rrd_pkg::DATA_W-1:0]    cfg_data
);

    // command and status between sequencer and datapath
    rrd_pkg::ctrl_cmd_t cmd;
    rrd_pkg::ctrl_sts_t sts;

    // sequencer: idle -> probe start entry -> scan entries -> serve if hit -> emit; loads skip to emit
    rrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .sts      (sts),
        .in_ready (req.ready),
        .cmd      (cmd)
    );

    // tables, time keeping, scan compare and the output register
    rrd_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_mode         (req.mode),
        .req_slot         (req.slot),
        .req_arrival      (req.arrival),
        .req_burst        (req.burst),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .rsp_kind         (rsp.kind),
        .rsp_served_slot  (rsp.served_slot),
        .rsp_slice_length (rsp.slice_length),
        .rsp_slice_start  (rsp.slice_start),
        .rsp_slice_stop   (rsp.slice_stop),
        .rsp_new_segment  (rsp.new_segment)
    );

endmodule

// ===== tb/sv/tb_round_robin_dispatcher.sv =====
// testbench for the round-robin time-slice dispatcher: directed and random runs
`timescale 1ns / 1ps

module tb_round_robin_dispatcher;
    import rrd_pkg::*;

    // cycles allowed after the last result before the block counts as idle:
    // a dispatch scans at most sixteen entries, plus its take, probe, serve and emit steps
    localparam int SETTLE_CYCLES = 24;
    // cycles in a row without any transaction before the run is abandoned
    localparam int STALL_LIMIT   = 1000;
    localparam logic [TIME_W-1:0] TIME_CEILING = '1;

    // one response transaction as the scheduler should produce it
    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   served_slot;
        logic [DATA_W-1:0]   slice_length;
        logic [TIME_W-1:0]   slice_start;
        logic [TIME_W-1:0]   slice_stop;
        logic                new_segment;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DATA_W-1:0]     cfg_data;

    rrd_req_if req_ch ();
    rrd_rsp_if rsp_ch ();

    round_robin_dispatcher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // scheduler mirror: process table, clock and round-robin pointers
    logic [DATA_W-1:0]   sched_arrival   [MAX_PROCESSES];
    logic [DATA_W-1:0]   sched_remaining [MAX_PROCESSES];
    logic [TIME_W-1:0]   sched_clock     = '0;
    int                  sched_cursor    = 0;
    int                  sched_prev_slot = 0;
    bit                  sched_prev_valid = 1'b0;
    logic [DATA_W-1:0]   sched_quantum   = 16'd1;
    logic [PCOUNT_W-1:0] sched_count     = 5'd16;

    // scheduler answers still owed by the block, oldest first
    outcome_t scheduler_answers [$];
    outcome_t answer_due;
    int       mismatches   = 0;
    int       stall_cycles = 0;
    int       src_idle_pct = 0;
    int       snk_idle_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < MAX_PROCESSES; i++)
        begin
            sched_arrival[i]   = '0;
            sched_remaining[i] = '0;
        end
    end

    // ------------------------------------------------------------------
    // scheduler prediction
    // ------------------------------------------------------------------

    // entries actually scanned: zero counts as one, anything past the table as the table
    function automatic int count_in_use();
        if (sched_count == 0)
            return 1;
        else if (sched_count > MAX_PROCESSES)
            return MAX_PROCESSES;
        else
            return sched_count;
    endfunction

    // advance the mirror by one request transaction and queue its answer
    function automatic void run_scheduler(input logic [0:0] mode,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [DATA_W-1:0] arrival,
                                          input logic [DATA_W-1:0] burst);
        outcome_t          ans;
        int                cnt;
        int                pos;
        int                k;
        int                found;
        bit                any_work;
        logic [DATA_W-1:0] slice_q;
        logic [DATA_W-1:0] charge;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] t1;

        ans = '0;
        if (mode == MODE_LOAD)
        begin
            // every 4-bit slot lies inside the table, so a load always lands
            sched_arrival[slot]   = arrival;
            sched_remaining[slot] = burst;
            ans.kind = KIND_LOADED;
        end
        else
        begin
            cnt = count_in_use();
            any_work = 1'b0;
            for (int i = 0; i < cnt; i++)
                if (sched_remaining[i] != 0)
                    any_work = 1'b1;

            if (!any_work)
            begin
                ans.kind        = KIND_ALL_DONE;
                ans.slice_start = sched_clock;
                ans.slice_stop  = sched_clock;
            end
            else
            begin
                // stale pointer wraps; a start entry not yet arrived restarts at entry 0
                pos = (sched_cursor < cnt) ? sched_cursor : 0;
                if (sched_arrival[pos] > sched_clock)
                    pos = 0;
                found = -1;
                for (int i = 0; i < cnt; i++)
                begin
                    k = (pos + i) % cnt;
                    if (found < 0 && sched_arrival[k] <= sched_clock && sched_remaining[k] != 0)
                        found = k;
                end

                if (found < 0)
                begin
                    // idle tick: one unit of time unless already at the ceiling
                    t1 = (sched_clock == TIME_CEILING) ? sched_clock : sched_clock + 1;
                    ans.kind         = KIND_IDLE_TICK;
                    ans.slice_length = DATA_W'(t1 - sched_clock);
                    ans.slice_start  = sched_clock;
                    ans.slice_stop   = t1;
                    sched_clock      = t1;
                    sched_prev_valid = 1'b0;
                end
                else
                begin
                    slice_q = (sched_quantum == 0) ? 16'd1 : sched_quantum;
                    charge  = (sched_remaining[found] < slice_q) ? sched_remaining[found]
                                                                 : slice_q;
                    sum = {1'b0, sched_clock} + charge;
                    t1  = sum[TIME_W] ? TIME_CEILING : sum[TIME_W-1:0];

                    ans.kind         = KIND_DISPATCHED;
                    ans.served_slot  = found[SLOT_W-1:0];
                    ans.slice_length = charge;
                    ans.slice_start  = sched_clock;
                    ans.slice_stop   = t1;
                    ans.new_segment  = !sched_prev_valid || (found != sched_prev_slot);

                    // the full slice is charged even when the clock saturates
                    sched_remaining[found] = sched_remaining[found] - charge;
                    sched_clock      = t1;
                    sched_prev_slot  = found;
                    sched_prev_valid = 1'b1;
                    sched_cursor     = (found + 1 >= cnt) ? 0 : found + 1;
                end
            end
        end
        scheduler_answers.push_back(ans);
    endfunction

    // ------------------------------------------------------------------
    // response side: random backpressure and result checking
    // ------------------------------------------------------------------

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (scheduler_answers.size() == 0)
            begin
                $error("response transaction with no request outstanding: kind %0d",
                       rsp_ch.kind);
                mismatches++;
            end
            else
            begin
                answer_due = scheduler_answers.pop_front();
                if (rsp_ch.kind !== answer_due.kind)
                begin
                    $error("kind: expected %0d, got %0d", answer_due.kind, rsp_ch.kind);
                    mismatches++;
                end
                if (rsp_ch.served_slot !== answer_due.served_slot)
                begin
                    $error("served_slot: expected %0d, got %0d",
                           answer_due.served_slot, rsp_ch.served_slot);
                    mismatches++;
                end
                if (rsp_ch.slice_length !== answer_due.slice_length)
                begin
                    $error("slice_length: expected %0d, got %0d",
                           answer_due.slice_length, rsp_ch.slice_length);
                    mismatches++;
                end
                if (rsp_ch.slice_start !== answer_due.slice_start)
                begin
                    $error("slice_start: expected %0d, got %0d",
                           answer_due.slice_start, rsp_ch.slice_start);
                    mismatches++;
                end
                if (rsp_ch.slice_stop !== answer_due.slice_stop)
                begin
                    $error("slice_stop: expected %0d, got %0d",
                           answer_due.slice_stop, rsp_ch.slice_stop);
                    mismatches++;
                end
                if (rsp_ch.new_segment !== answer_due.new_segment)
                begin
                    $error("new_segment: expected %0d, got %0d",
                           answer_due.new_segment, rsp_ch.new_segment);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: any transaction on either channel counts as progress
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one request transaction; entered and left right after a rising edge
    task automatic send_request(input logic [0:0] mode,
                                input logic [SLOT_W-1:0] slot,
                                input logic [DATA_W-1:0] arrival,
                                input logic [DATA_W-1:0] burst);
        run_scheduler(mode, slot, arrival, burst);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.mode    <= mode;
        req_ch.slot    <= slot;
        req_ch.arrival <= arrival;
        req_ch.burst   <= burst;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
    endtask

    // hold off new requests until every answer is in and the block has gone quiet
    task automatic wait_for_quiet();
        req_ch.valid <= 1'b0;
        while (scheduler_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register writes happen only with the block idle
    task automatic configure(input logic [DATA_W-1:0] quantum_word,
                             input logic [DATA_W-1:0] count_word);
        wait_for_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_QUANTUM;
        cfg_data  <= quantum_word;
        @(posedge clk);
        cfg_index <= CFG_PCOUNT;
        cfg_data  <= count_word;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sched_quantum = quantum_word;
        sched_count   = count_word[PCOUNT_W-1:0];
    endtask

    // mostly plausible workload: loads into live slots with arrivals near the clock,
    // dispatches with junk payload; wide mode adds full-range bursts
    task automatic send_random_request(input bit wide);
        int                roll;
        int                cnt;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] arrival;
        logic [DATA_W-1:0] burst;
        logic [TIME_W-1:0] horizon;

        cnt     = count_in_use();
        horizon = (sched_clock > 65535) ? 65535 : sched_clock;
        roll    = $urandom_range(0, 99);
        if (roll < 55)
            send_request(MODE_DISPATCH, SLOT_W'($urandom), DATA_W'($urandom),
                         DATA_W'($urandom));
        else
        begin
            slot = (roll < 92) ? SLOT_W'($urandom_range(0, cnt - 1))
                               : SLOT_W'($urandom_range(0, 15));
            roll = $urandom_range(0, 99);
            if (roll < 50)
                arrival = DATA_W'($urandom_range(0, horizon));
            else if (roll < 90)
                arrival = (horizon + 24 > 65535) ? 16'hFFFF
                                                 : DATA_W'(horizon + $urandom_range(1, 24));
            else
                arrival = DATA_W'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 10)
                burst = '0;
            else if (roll < 90 || !wide)
                burst = DATA_W'($urandom_range(1, 40));
            else
                burst = DATA_W'($urandom);
            send_request(MODE_LOAD, slot, arrival, burst);
        end
        // now and then let everything drain before going on
        if ($urandom_range(0, 99) == 0)
            wait_for_quiet();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty table right after reset: all work done at time zero, no arrival read
    task automatic test_done_after_reset();
        send_request(MODE_DISPATCH, 4'hF, 16'hFFFF, 16'hFFFF);
    endtask

    // zero quantum acts as one, zero count as one entry
    task automatic test_min_config();
        configure(16'd0, 16'd0);
        send_request(MODE_LOAD, 4'd0, 16'd0, 16'd2);
        repeat (3) send_request(MODE_DISPATCH, 4'd0, 16'd0, 16'd0);
    endtask

    // restart at entry 0 when the start entry has not arrived, idle ticks that
    // break a segment, and a search pointer left stale by a smaller count
    task automatic test_idle_and_restart();
        configure(16'd3, 16'd3);
        send_request(MODE_LOAD, 4'd0, 16'd0, 16'd1);
        send_request(MODE_LOAD, 4'd1, 16'd20, 16'd4);
        send_request(MODE_LOAD, 4'd2, 16'd3, 16'hFFFF);
        send_request(MODE_LOAD, 4'd15, 16'hFFFF, 16'hFFFF);
        repeat (3) send_request(MODE_DISPATCH, 4'd0, 16'd0, 16'd0);
        // retire entry 2 so nothing is ready
        send_request(MODE_LOAD, 4'd2, 16'd3, 16'd0);
        send_request(MODE_DISPATCH, 4'd0, 16'd0, 16'd0);
        send_request(MODE_LOAD, 4'd1, 16'd4, 16'd4);
        send_request(MODE_DISPATCH, 4'd0, 16'd0, 16'd0);
        // pointer now at entry 2, count drops to 2
        configure(16'd3, 16'd2);
        repeat (2) send_request(MODE_DISPATCH, 4'd0, 16'd0, 16'd0);
    endtask

    // largest quantum against the largest burst; count written with high junk bits
    task automatic test_wide_slice();
        configure(16'hFFFF, 16'h0022);
        send_request(MODE_LOAD, 4'd0, 16'd0, 16'hFFFF);
        repeat (2) send_request(MODE_DISPATCH, 4'd0, 16'd0, 16'd0);
    endtask

    // random workload under three idling schemes and several register settings
    task automatic test_random();
        int                scheme;
        int                sel;
        logic [DATA_W-1:0] quantum_word;
        logic [DATA_W-1:0] count_word;

        // every table entry gets written before the full table is searched
        configure(16'd4, 16'd16);
        for (int s = 0; s < MAX_PROCESSES; s++)
            send_request(MODE_LOAD, SLOT_W'(s), DATA_W'($urandom_range(0, 64)),
                         DATA_W'($urandom_range(0, 40)));

        for (scheme = 0; scheme < 3; scheme++)
        begin
            case (scheme)
                0:
                begin
                    src_idle_pct = 15;
                    snk_idle_pct = 64;
                end
                1:
                begin
                    src_idle_pct = 64;
                    snk_idle_pct = 15;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (int p = 0; p < 3; p++)
            begin
                sel = $urandom_range(0, 4);
                case (sel)
                    0:       quantum_word = 16'd0;
                    1:       quantum_word = 16'd1;
                    2:       quantum_word = 16'hFFFF;
                    3:       quantum_word = DATA_W'($urandom_range(2, 8));
                    default: quantum_word = DATA_W'($urandom);
                endcase
                sel = $urandom_range(0, 4);
                case (sel)
                    0:       count_word = 16'd0;
                    1:       count_word = 16'd16;
                    2:       count_word = 16'd31;
                    3:       count_word = DATA_W'($urandom_range(1, 16));
                    default: count_word = DATA_W'($urandom);
                endcase
                configure(quantum_word, count_word);
                repeat (145) send_random_request(scheme == 2 && p == 2);
            end
        end
    endtask

    initial
    begin
        req_ch.valid   <= 1'b0;
        req_ch.mode    <= MODE_LOAD;
        req_ch.slot    <= '0;
        req_ch.arrival <= '0;
        req_ch.burst   <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_QUANTUM;
        cfg_data       <= '0;
        rst_n          <= 1'b0;
        src_idle_pct   = 15;
        snk_idle_pct   = 64;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_done_after_reset();
        test_min_config();
        test_idle_and_restart();
        test_wide_slice();
        test_random();

        wait_for_quiet();
        if (mismatches == 0 && scheduler_answers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rrd_pkg.sv
rtl/rrd_req_if.sv
rtl/rrd_rsp_if.sv
rtl/rrd_ram.sv
rtl/rrd_ctrl.sv
rtl/rrd_datapath.sv
rtl/round_robin_dispatcher.sv
tb/sv/tb_round_robin_dispatcher.sv
